// File: rtl/core/motor_setpoint_ramp_supervisor_unit_macros.svh
// Assertion helpers used by the ramp stage RTL (msrs_ramp).
`ifndef MOTOR_SETPOINT_RAMP_SUPERVISOR_UNIT_MACROS_SVH
`define MOTOR_SETPOINT_RAMP_SUPERVISOR_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MSRS_ASSERT_IMPL(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MSRS_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/msrs_pkg.sv
`timescale 1ns / 1ps

package msrs_pkg;

  // Depth of the tach averaging ring. It must be a power of two so that the
  // average is a plain right shift of the running total.
  localparam int AVG_DEPTH = 8;
  localparam int AVG_SHIFT = $clog2(AVG_DEPTH);
  localparam int POS_W     = AVG_SHIFT;
  localparam int TOTAL_W   = 8 + AVG_SHIFT;

  typedef enum logic [1:0] {
    CMD_SAMPLE = 2'd0,
    CMD_START  = 2'd1,
    CMD_STOP   = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_RUN   = 3'd1,
    PH_ACCEL = 3'd2,
    PH_DECEL = 3'd3,
    PH_CONST = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    REG_MAX_SPEED      = 2'd0,
    REG_SPIN_THRESHOLD = 2'd1,
    REG_ACCEL_STEP     = 2'd2,
    REG_DECEL_STEP     = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [7:0]  max_speed;
    logic [7:0]  spin_threshold;
    logic [15:0] accel_step;
    logic [15:0] decel_step;
  } cfg_t;

  // One item after scaling, handed from the scaler to the ramp stage.
  typedef struct packed {
    logic [1:0] cmd;
    logic       due;
    logic [7:0] target;
    logic [7:0] tach_scaled;
  } scaled_t;

  // Floor of x / 1023 for x below 1023 * 256. With q0 = x >> 10 the
  // remainder x - 1023 * q0 equals (x mod 1024) + q0, which stays below
  // twice 1023, so one compare fixes the quotient.
  function automatic logic [7:0] div1023(input logic [17:0] x);
    logic [7:0]  q0;
    logic [10:0] rem;
    q0  = x[17:10];
    rem = {1'b0, x[9:0]} + {3'b000, q0};
    return (rem >= 11'd1023) ? 8'(q0 + 8'd1) : q0;
  endfunction

endpackage

// File: rtl/core/msrs_scale.sv
`timescale 1ns / 1ps

module msrs_scale (
  input  logic                clk,
  input  logic                rst_n,
  input  msrs_pkg::cfg_t      cfg,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_command,
  input  logic [9:0]          in_pot_sample,
  input  logic [9:0]          in_tach_sample,
  input  logic                in_check_due,
  output logic                sc_valid,
  input  logic                sc_ready,
  output msrs_pkg::scaled_t   sc_item
);

  logic              s0_valid_r, s0_valid_nxt;
  logic [1:0]        s0_cmd_r;
  logic [9:0]        s0_pot_r;
  logic [9:0]        s0_tach_r;
  logic              s0_due_r;
  logic              s1_valid_r, s1_valid_nxt;
  msrs_pkg::scaled_t s1_item_r, s1_item_nxt;
  logic              s0_free, s1_free;
  logic [17:0]       pot_prod, tach_prod;

  assign s1_free  = !s1_valid_r || sc_ready;
  assign s0_free  = !s0_valid_r || s1_free;
  assign in_ready = s0_free;

  assign s0_valid_nxt = s0_free ? in_valid : s0_valid_r;
  assign s1_valid_nxt = s1_free ? s0_valid_r : s1_valid_r;

  // pot * max_speed and tach * 255, both at most 1023 * 255.
  assign pot_prod  = {8'd0, s0_pot_r} * {10'd0, cfg.max_speed};
  assign tach_prod = {s0_tach_r, 8'd0} - {8'd0, s0_tach_r};

  always_comb begin
    s1_item_nxt.cmd         = s0_cmd_r;
    s1_item_nxt.due         = s0_due_r;
    s1_item_nxt.target      = msrs_pkg::div1023(pot_prod);
    s1_item_nxt.tach_scaled = msrs_pkg::div1023(tach_prod);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
      s1_valid_r <= 1'b0;
    end else begin
      s0_valid_r <= s0_valid_nxt;
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_free && in_valid) begin
      s0_cmd_r  <= in_command;
      s0_pot_r  <= in_pot_sample;
      s0_tach_r <= in_tach_sample;
      s0_due_r  <= in_check_due;
    end
    if (s1_free && s0_valid_r) begin
      s1_item_r <= s1_item_nxt;
    end
  end

  assign sc_valid = s1_valid_r;
  assign sc_item  = s1_item_r;

endmodule

// File: rtl/core/msrs_ramp.sv
`timescale 1ns / 1ps
`include "motor_setpoint_ramp_supervisor_unit_macros.svh"

module msrs_ramp (
  input  logic                clk,
  input  logic                rst_n,
  input  msrs_pkg::cfg_t      cfg,
  input  logic                sc_valid,
  output logic                sc_ready,
  input  msrs_pkg::scaled_t   sc_item,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [15:0]         out_speed_setpoint,
  output logic [7:0]          out_speed_target,
  output logic [7:0]          out_tach_average,
  output logic [2:0]          out_motor_phase,
  output logic                out_tach_fault,
  output logic                out_regulator_auto
);

  localparam int AVG_W = msrs_pkg::TOTAL_W - msrs_pkg::AVG_SHIFT;

  logic [7:0]                    ring_r [msrs_pkg::AVG_DEPTH];
  logic [msrs_pkg::POS_W-1:0]    pos_r, pos_nxt;
  logic [msrs_pkg::TOTAL_W-1:0]  total_r, total_nxt;
  logic [15:0]                   setpoint_r, setpoint_nxt;
  logic                          enabled_r, enabled_nxt;
  logic                          ramping_r, ramping_nxt;
  logic                          fault_r, fault_nxt;
  logic                          auto_r, auto_nxt;
  msrs_pkg::phase_t              phase_r, phase_nxt;

  logic                          out_valid_r, out_valid_nxt;
  logic [15:0]                   o_setpoint_r;
  logic [7:0]                    o_target_r, o_target_nxt;
  logic [7:0]                    o_avg_r, o_avg_nxt;
  logic [2:0]                    o_phase_r;
  logic                          o_fault_r, o_auto_r;

  logic                          take, ring_write;
  logic [AVG_W-1:0]              avg_now;
  logic [15:0]                   tgt_fx;
  logic [16:0]                   ramp_up;

  assign sc_ready = !out_valid_r || out_ready;
  assign take     = sc_valid && sc_ready;

  assign tgt_fx  = {sc_item.target, 8'h00};
  assign ramp_up = {1'b0, setpoint_r} + {1'b0, cfg.accel_step};
  assign avg_now = AVG_W'(total_r >> msrs_pkg::AVG_SHIFT);

  always_comb begin
    pos_nxt      = pos_r;
    total_nxt    = total_r;
    setpoint_nxt = setpoint_r;
    enabled_nxt  = enabled_r;
    ramping_nxt  = ramping_r;
    fault_nxt    = fault_r;
    auto_nxt     = auto_r;
    phase_nxt    = phase_r;
    ring_write   = 1'b0;
    o_target_nxt = 8'd0;
    o_avg_nxt    = 8'(avg_now);
    case (msrs_pkg::cmd_t'(sc_item.cmd))
      msrs_pkg::CMD_START: begin
        if (!enabled_r) begin
          enabled_nxt = 1'b1;
          ramping_nxt = 1'b1;
          fault_nxt   = 1'b0;
        end
      end
      msrs_pkg::CMD_STOP: begin
        enabled_nxt = 1'b0;
        ramping_nxt = 1'b0;
      end
      msrs_pkg::CMD_SAMPLE: begin
        ring_write   = 1'b1;
        total_nxt    = total_r - msrs_pkg::TOTAL_W'(ring_r[pos_r])
                       + msrs_pkg::TOTAL_W'(sc_item.tach_scaled);
        pos_nxt      = (pos_r == msrs_pkg::POS_W'(msrs_pkg::AVG_DEPTH - 1)) ?
                       '0 : pos_r + 1'b1;
        o_target_nxt = sc_item.target;
        o_avg_nxt    = 8'(total_nxt >> msrs_pkg::AVG_SHIFT);

        // A due check with a demanded speed but no tach signal trips the alarm.
        if (sc_item.due && enabled_r && (sc_item.target >= cfg.spin_threshold) &&
            (o_avg_nxt == 8'd0)) begin
          auto_nxt    = 1'b0;
          enabled_nxt = 1'b0;
          ramping_nxt = 1'b0;
          fault_nxt   = 1'b1;
        end

        if (enabled_nxt && !fault_nxt) begin
          auto_nxt = 1'b1;
          if (ramping_nxt) begin
            setpoint_nxt = (ramp_up < {1'b0, tgt_fx}) ? ramp_up[15:0] : tgt_fx;
            if (setpoint_nxt >= tgt_fx) begin
              ramping_nxt = 1'b0;
              phase_nxt   = msrs_pkg::PH_CONST;
            end else begin
              phase_nxt   = msrs_pkg::PH_ACCEL;
            end
          end else begin
            setpoint_nxt = tgt_fx;
          end
        end else begin
          setpoint_nxt = (setpoint_r > cfg.decel_step) ?
                         16'(setpoint_r - cfg.decel_step) : 16'd0;
          phase_nxt    = msrs_pkg::PH_DECEL;
          if ((setpoint_nxt == 16'd0) && (o_avg_nxt == 8'd0)) begin
            auto_nxt  = 1'b0;
            phase_nxt = msrs_pkg::PH_IDLE;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_nxt = take ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < msrs_pkg::AVG_DEPTH; i++) begin
        ring_r[i] <= 8'd0;
      end
      pos_r       <= '0;
      total_r     <= '0;
      setpoint_r  <= 16'd0;
      enabled_r   <= 1'b0;
      ramping_r   <= 1'b0;
      fault_r     <= 1'b0;
      auto_r      <= 1'b0;
      phase_r     <= msrs_pkg::PH_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (take) begin
        if (ring_write) begin
          ring_r[pos_r] <= sc_item.tach_scaled;
        end
        pos_r      <= pos_nxt;
        total_r    <= total_nxt;
        setpoint_r <= setpoint_nxt;
        enabled_r  <= enabled_nxt;
        ramping_r  <= ramping_nxt;
        fault_r    <= fault_nxt;
        auto_r     <= auto_nxt;
        phase_r    <= phase_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      o_setpoint_r <= setpoint_nxt;
      o_target_r   <= o_target_nxt;
      o_avg_r      <= o_avg_nxt;
      o_phase_r    <= phase_nxt;
      o_fault_r    <= fault_nxt;
      o_auto_r     <= auto_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_speed_setpoint = o_setpoint_r;
  assign out_speed_target   = o_target_r;
  assign out_tach_average   = o_avg_r;
  assign out_motor_phase    = o_phase_r;
  assign out_tach_fault     = o_fault_r;
  assign out_regulator_auto = o_auto_r;

  `MSRS_ASSERT_IMPL(a_fault_stops, clk, rst_n, fault_r, !enabled_r, "alarm latched while enabled")
  `MSRS_ASSERT_IMPL(a_ramp_enabled, clk, rst_n, ramping_r, enabled_r, "ramping while disabled")
  `MSRS_ASSERT_IMPL(a_idle_manual, clk, rst_n, phase_r == msrs_pkg::PH_IDLE, !auto_r, "idle in auto")
  `MSRS_ASSERT_NEXT(a_hold_state, clk, rst_n, !take, $stable(setpoint_r) && $stable(total_r), "state moved without a beat")

endmodule

// File: rtl/core/motor_setpoint_ramp_supervisor_unit.sv
`timescale 1ns / 1ps

// Motor setpoint ramp supervisor. Each input beat is a start click, a stop
// click or a sample (pot reading, tach reading, timeout-due flag), and each
// one yields exactly one result beat carrying the 8.8 setpoint, the scaled
// target, the tach average, the motor phase, the alarm and the regulator
// mode. The block takes one beat per clock cycle while the result channel
// is not stalled. An accepted beat is held in the input register, then in
// the scaling stage's output register (pot times max_speed and the tach
// times 255, each divided by 1023), and then in the result register, which
// is loaded from the ramp stage, whose state update is combinational so that
// consecutive beats follow without gaps. The ready signal only drops while
// the result register is full and not taken and the two stages behind it
// are occupied. The tach ring is cleared directly by reset, so no clearing
// pass is needed. Configuration registers may only be written while no beat
// is in flight.

module motor_setpoint_ramp_supervisor_unit (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration write port.
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  // Input channel.
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_command,
  input  logic [9:0]  in_pot_sample,
  input  logic [9:0]  in_tach_sample,
  input  logic        in_check_due,
  // Result channel.
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_speed_setpoint,
  output logic [7:0]  out_speed_target,
  output logic [7:0]  out_tach_average,
  output logic [2:0]  out_motor_phase,
  output logic        out_tach_fault,
  output logic        out_regulator_auto
);

  msrs_pkg::cfg_t    cfg_r, cfg_nxt;
  logic              sc_valid, sc_ready;
  msrs_pkg::scaled_t sc_item;

  // Register file. Narrow registers take the low bits of the write data.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (msrs_pkg::reg_idx_t'(cfg_index))
        msrs_pkg::REG_MAX_SPEED:      cfg_nxt.max_speed      = cfg_wdata[7:0];
        msrs_pkg::REG_SPIN_THRESHOLD: cfg_nxt.spin_threshold = cfg_wdata[7:0];
        msrs_pkg::REG_ACCEL_STEP:     cfg_nxt.accel_step     = cfg_wdata;
        msrs_pkg::REG_DECEL_STEP:     cfg_nxt.decel_step     = cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // Reset values: full-scale pot range, no spin threshold, an acceleration
  // step of about 0.1 and a deceleration step of 0.5 per sample.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_speed      <= 8'd255;
      cfg_r.spin_threshold <= 8'd0;
      cfg_r.accel_step     <= 16'd26;
      cfg_r.decel_step     <= 16'd128;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Input register and scaling stage.
  msrs_scale u_scale (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_command     (in_command),
    .in_pot_sample  (in_pot_sample),
    .in_tach_sample (in_tach_sample),
    .in_check_due   (in_check_due),
    .sc_valid       (sc_valid),
    .sc_ready       (sc_ready),
    .sc_item        (sc_item)
  );

  // Tach averaging, alarm check, setpoint ramp and the result register.
  msrs_ramp u_ramp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg_r),
    .sc_valid           (sc_valid),
    .sc_ready           (sc_ready),
    .sc_item            (sc_item),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_speed_setpoint (out_speed_setpoint),
    .out_speed_target   (out_speed_target),
    .out_tach_average   (out_tach_average),
    .out_motor_phase    (out_motor_phase),
    .out_tach_fault     (out_tach_fault),
    .out_regulator_auto (out_regulator_auto)
  );

endmodule
